// File: src/rrts_pkg.sv
package rrts_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam logic [15:0] SLICE_LEN_RESET = 16'd500;
  localparam logic [4:0] FIRST_ID = 5'd1;

  typedef enum logic [2:0] {
    ACT_SPAWN    = 3'd0,
    ACT_DISPATCH = 3'd1,
    ACT_SLICE    = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_RESTART  = 3'd4,
    ACT_QUERY    = 3'd5,
    ACT_LIMIT    = 3'd6,
    ACT_NONE     = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_IDLE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TH_RUNNING      = 2'd0,
    TH_COMPLETED    = 2'd1,
    TH_DISCONTINUED = 2'd2
  } thread_state_t;

  localparam int REG_SLICE_LEN = 0;

endpackage

// File: src/round_robin_thread_scheduler.sv
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_tvalid/s_tready          command: action (tuser), id, root, finished, limit
// m_axis    out  m_tvalid/m_tready          response: status, id, slot, state, all_done
// apb       in   psel/penable/pwrite/pready slice length register at address 0
//
// One command at a time; the entry table has a single registered read port, so each
// entry visit is a read step then a check step. Spawn writes on accept; lookups and
// dispatch visit entries in turn; slice end: current entry, then each entry and ancestors.
// Reset clears counters and pointers and reloads the slice length; table entries are valid
// below the count. A waiting response does not block the next command; only a full output
// register holds the sequencer at its response step.
module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] action
  input  logic [2:0]  s_tuser,
  // [4:0] target_id, [5] root, [6] finished, [31:7] limit_value
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [6:2] result_id, [10:7] result_slot, [12:11] state_code, [13] all_done
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [4:0]    id;
    thread_state_t st;
    logic          has_parent;
    logic [SW-1:0] parent;
    logic [24:0]   budget;
  } entry_t;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_FRD  = 12'b000000000010,  // id lookup: read
    S_FCK  = 12'b000000000100,  // id lookup: compare and act
    S_DRD  = 12'b000000001000,  // dispatch scan
    S_DCK  = 12'b000000010000,
    S_ERD  = 12'b000000100000,  // slice end: current entry
    S_ECK  = 12'b000001000000,
    S_CRD  = 12'b000010000000,  // cleanup: visit entry
    S_CCK  = 12'b000100000000,
    S_WRD  = 12'b001000000000,  // cleanup: walk ancestor
    S_WCK  = 12'b010000000000,
    S_RESP = 12'b100000000000
  } seq_t;

  seq_t          state;
  logic [15:0]   slice_len;
  logic [CW-1:0] count;
  logic [CW-1:0] run_cnt;
  logic [SW-1:0] cur;
  logic [4:0]    next_id;
  logic [SW-1:0] idx;
  logic [SW-1:0] walk_j;
  logic [CW-1:0] steps;
  entry_t        hold;

  action_t       act;
  logic [4:0]    rid;
  logic          fin;
  logic [24:0]   limit;

  status_t       r_status;
  logic [4:0]    r_id;
  logic [SW-1:0] r_slot;
  logic [1:0]    r_scode;

  logic          we;
  logic [SW-1:0] waddr;
  entry_t        wdata;
  logic [SW-1:0] raddr;
  entry_t        rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;

  assign rdata = entry_t'(rdata_raw);

  rrts_table #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(entry_t))) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  // APB: single register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == 3'(4 * REG_SLICE_LEN)) ? {16'd0, slice_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_len <= SLICE_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_SLICE_LEN)) begin
      slice_len <= pwdata[15:0];
    end
  end

  assign s_tready = (state == S_IDLE);

  // round robin successor within the occupied slots
  function automatic logic [SW-1:0] wrap_next(input logic [SW-1:0] i, input logic [CW-1:0] n);
    logic [CW:0] nx;
    nx = {1'b0, CW'(i)} + 1'b1;
    wrap_next = (nx >= {1'b0, n}) ? '0 : SW'(nx);
  endfunction

  logic          last_idx;
  logic [24:0]   new_budget;
  thread_state_t new_st;
  logic [CW:0]   nxt_idx_w;

  assign nxt_idx_w = {1'b0, CW'(idx)} + 1'b1;
  assign last_idx  = (nxt_idx_w >= {1'b0, count});

  // slice end: finish mark, then charge the budget
  always_comb begin
    new_st     = fin ? TH_COMPLETED : TH_RUNNING;
    new_budget = rdata.budget;
    if (!rdata.budget[24]) begin
      if ({1'b0, rdata.budget[23:0]} <= {9'd0, slice_len}) begin
        new_st     = TH_DISCONTINUED;
        new_budget = '0;
      end else begin
        new_budget = rdata.budget - {9'd0, slice_len};
      end
    end
  end

  // table ports
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    raddr = idx;
    case (state)
      S_IDLE: begin
        waddr           = SW'(count);
        wdata.id        = next_id;
        wdata.st        = TH_RUNNING;
        wdata.budget    = '1;
        wdata.has_parent = !s_tdata[5] && count != '0;
        wdata.parent    = wdata.has_parent ? cur : '0;
        we = s_tvalid && action_t'(s_tuser) == ACT_SPAWN && count < CW'(TABLE_DEPTH);
      end
      S_FCK: begin
        if (rdata.id == rid) begin
          we = (act != ACT_QUERY);
          if (act == ACT_STOP) wdata.st = TH_COMPLETED;
          if (act == ACT_RESTART) wdata.st = TH_RUNNING;
          if (act == ACT_LIMIT) wdata.budget = limit;
        end
      end
      S_ERD: raddr = cur;
      S_ECK: begin
        waddr        = cur;
        wdata.st     = new_st;
        wdata.budget = new_budget;
        we           = (rdata.st == TH_RUNNING);
      end
      S_WRD: raddr = walk_j;
      S_WCK: begin
        wdata    = hold;
        wdata.st = TH_COMPLETED;
        we       = ({1'b0, walk_j} < {1'b0, count}) && rdata.st == TH_COMPLETED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      run_cnt  <= '0;
      cur      <= '0;
      next_id  <= FIRST_ID;
      m_tvalid <= 1'b0;
    end else begin
      // the response step sets valid itself
      if (m_tvalid && m_tready && state != S_RESP) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act      <= action_t'(s_tuser);
            rid      <= s_tdata[4:0];
            fin      <= s_tdata[6];
            limit    <= s_tdata[31:7];
            r_status <= STS_OK;
            r_id     <= '0;
            r_slot   <= '0;
            r_scode  <= '0;
            idx      <= '0;
            state    <= S_RESP;
            case (action_t'(s_tuser))
              ACT_SPAWN: begin
                if (count >= CW'(TABLE_DEPTH)) begin
                  r_status <= STS_FULL;
                end else begin
                  r_id    <= next_id;
                  r_slot  <= SW'(count);
                  count   <= count + 1'b1;
                  run_cnt <= run_cnt + 1'b1;
                  next_id <= next_id + 1'b1;
                end
              end
              ACT_DISPATCH: begin
                if (run_cnt == '0 || count == '0 || {1'b0, cur} >= {1'b0, count}) begin
                  r_status <= STS_IDLE;
                end else begin
                  idx   <= wrap_next(cur, count);
                  state <= S_DRD;
                end
              end
              ACT_SLICE: begin
                if (count == '0 || {1'b0, cur} >= {1'b0, count}) begin
                  r_status <= STS_IDLE;
                end else begin
                  state <= S_ERD;
                end
              end
              ACT_STOP, ACT_RESTART, ACT_QUERY, ACT_LIMIT: begin
                if (count == '0) r_status <= STS_NOT_FOUND;
                else state <= S_FRD;
              end
              default: ;
            endcase
          end
        end
        S_FRD: state <= S_FCK;
        S_FCK: begin
          if (rdata.id == rid) begin
            r_id   <= rdata.id;
            r_slot <= idx;
            if (act == ACT_QUERY) r_scode <= rdata.st;
            if (act == ACT_STOP && rdata.st == TH_RUNNING) run_cnt <= run_cnt - 1'b1;
            if (act == ACT_RESTART && rdata.st != TH_RUNNING) run_cnt <= run_cnt + 1'b1;
            state <= S_RESP;
          end else if (last_idx) begin
            r_status <= STS_NOT_FOUND;
            state    <= S_RESP;
          end else begin
            idx   <= SW'(nxt_idx_w);
            state <= S_FRD;
          end
        end
        S_DRD: state <= S_DCK;
        S_DCK: begin
          // arriving back at the current slot ends the scan with it unchanged
          if (idx == cur || rdata.st == TH_RUNNING) begin
            cur    <= idx;
            r_id   <= rdata.id;
            r_slot <= idx;
            state  <= S_RESP;
          end else begin
            idx   <= wrap_next(idx, count);
            state <= S_DRD;
          end
        end
        S_ERD: state <= S_ECK;
        S_ECK: begin
          if (rdata.st != TH_RUNNING) begin
            r_status <= STS_IDLE;
            state    <= S_RESP;
          end else begin
            r_id   <= rdata.id;
            r_slot <= cur;
            if (new_st != TH_RUNNING) run_cnt <= run_cnt - 1'b1;
            idx   <= '0;
            state <= S_CRD;
          end
        end
        S_CRD: state <= S_CCK;
        S_CCK: begin
          hold <= rdata;
          if (rdata.st == TH_COMPLETED || !rdata.has_parent) begin
            if (last_idx) state <= S_RESP;
            else begin
              idx   <= SW'(nxt_idx_w);
              state <= S_CRD;
            end
          end else begin
            walk_j <= rdata.parent;
            steps  <= CW'(1);
            state  <= S_WRD;
          end
        end
        S_WRD: state <= S_WCK;
        S_WCK: begin
          if ({1'b0, walk_j} < {1'b0, count} && rdata.st != TH_COMPLETED &&
              rdata.has_parent && steps != CW'(TABLE_DEPTH)) begin
            walk_j <= rdata.parent;
            steps  <= steps + 1'b1;
            state  <= S_WRD;
          end else begin
            if (we && hold.st == TH_RUNNING) run_cnt <= run_cnt - 1'b1;
            if (last_idx) state <= S_RESP;
            else begin
              idx   <= SW'(nxt_idx_w);
              state <= S_CRD;
            end
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response register, loaded as the sequencer leaves its response step
  always_ff @(posedge clk) begin
    if (state == S_RESP && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, (run_cnt == '0), r_scode, 4'(r_slot), r_id, r_status};
    end
  end

`ifndef SYNTHESIS
  a_run_le_count: assert property (@(posedge clk) disable iff (rst) run_cnt <= count)
    else $error("running count above entry count");
  a_cur_in_table: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> {1'b0, cur} < {1'b0, count})
    else $error("current slot outside table");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a command while busy");
`endif

endmodule

// File: src/rrts_table.sv
module rrts_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read; data read in a cycle that writes the same address is never used
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: verif/tb_round_robin_thread_scheduler.sv
// Testbench for the round robin thread scheduler.
// Commands go in on the s side, responses come out on the m side.
// A scoreboard keeps its own copy of the thread table.
// For each command it works out the response and checks it in order.
module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  // Idle cycles that go by without any transfer before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 20000;

  // Thread table mirror. It predicts one response per command and checks responses in order.
  class sched_scoreboard;
    logic [4:0]    ids[DEPTH];
    thread_state_t st[DEPTH];
    int            par[DEPTH];
    bit            has_par[DEPTH];
    int            budget[DEPTH];
    int            count;
    int            cur;
    logic [4:0]    nid;
    int unsigned   slice;
    logic [15:0]   pending[$];
    int            errors;

    function new();
      count = 0;
      cur = 0;
      nid = FIRST_ID;
      slice = SLICE_LEN_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function bit any_running();
      for (int i = 0; i < count; i++) begin
        if (st[i] == TH_RUNNING) return 1;
      end
      return 0;
    endfunction

    // Walk up the parent links looking for a completed thread, itself included.
    function bit doomed(int slot);
      int j;
      j = slot;
      for (int n = 0; n <= DEPTH; n++) begin
        if (j >= count) return 0;
        if (st[j] == TH_COMPLETED) return 1;
        if (!has_par[j]) return 0;
        j = par[j];
      end
      return 0;
    endfunction

    function int lookup(logic [4:0] id);
      for (int i = 0; i < count; i++) begin
        if (ids[i] == id) return i;
      end
      return -1;
    endfunction

    function void note(logic [39:0] cmd);
      action_t          act;
      logic [4:0]       rid;
      bit               fin;
      logic signed [24:0] lim;
      status_t          sts;
      logic [4:0]       rsp_id;
      logic [3:0]       rsp_slot;
      logic [1:0]       code;
      logic [15:0]      rsp_word;
      int               s;
      int               i;
      act = action_t'(cmd[2:0]);
      rid = cmd[7:3];
      fin = cmd[9];
      lim = cmd[34:10];
      sts = STS_OK;
      rsp_id = '0;
      rsp_slot = '0;
      code = '0;
      case (act)
        ACT_SPAWN: begin
          if (count >= DEPTH) begin
            sts = STS_FULL;
          end else begin
            s = count;
            ids[s] = nid;
            st[s] = TH_RUNNING;
            budget[s] = -1;
            has_par[s] = !cmd[8] && count > 0;
            par[s] = has_par[s] ? cur : 0;
            count++;
            rsp_id = nid;
            rsp_slot = 4'(s);
            nid = nid + 5'd1;
          end
        end
        ACT_DISPATCH: begin
          if (!any_running() || count == 0 || cur >= count) begin
            sts = STS_IDLE;
          end else begin
            i = (cur + 1) % count;
            while (i != cur) begin
              if (st[i] == TH_RUNNING) begin
                cur = i;
                break;
              end
              i = (i + 1) % count;
            end
            rsp_id = ids[cur];
            rsp_slot = 4'(cur);
          end
        end
        ACT_SLICE: begin
          if (count == 0 || cur >= count || st[cur] != TH_RUNNING) begin
            sts = STS_IDLE;
          end else begin
            s = cur;
            if (fin) st[s] = TH_COMPLETED;
            if (budget[s] >= 0) begin
              if (budget[s] <= slice) begin
                st[s] = TH_DISCONTINUED;
                budget[s] = 0;
              end else begin
                budget[s] = budget[s] - slice;
              end
            end
            // orphan sweep, in slot order so earlier updates count for later slots
            for (int k = 0; k < count; k++) begin
              if (st[k] != TH_COMPLETED && has_par[k] && doomed(k)) st[k] = TH_COMPLETED;
            end
            rsp_id = ids[s];
            rsp_slot = 4'(s);
          end
        end
        ACT_STOP, ACT_RESTART, ACT_QUERY, ACT_LIMIT: begin
          s = lookup(rid);
          if (s < 0) begin
            sts = STS_NOT_FOUND;
          end else begin
            if (act == ACT_STOP) st[s] = TH_COMPLETED;
            else if (act == ACT_RESTART) st[s] = TH_RUNNING;
            else if (act == ACT_QUERY) code = st[s];
            else budget[s] = lim;
            rsp_id = ids[s];
            rsp_slot = 4'(s);
          end
        end
        default: ;
      endcase
      rsp_word = {2'b00, !any_running(), code, rsp_slot, rsp_id, sts};
      pending = {pending, rsp_word};
    endfunction

    task check(logic [15:0] got);
      logic [15:0] exp_rsp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response %h", got));
      end else begin
        exp_rsp = pending.pop_front();
        if (got[1:0] != exp_rsp[1:0])
          report($sformatf("status %0d, want %0d", got[1:0], exp_rsp[1:0]));
        if (got[6:2] != exp_rsp[6:2])
          report($sformatf("result_id %0d, want %0d", got[6:2], exp_rsp[6:2]));
        if (got[10:7] != exp_rsp[10:7])
          report($sformatf("result_slot %0d, want %0d", got[10:7], exp_rsp[10:7]));
        if (got[12:11] != exp_rsp[12:11])
          report($sformatf("state_code %0d, want %0d", got[12:11], exp_rsp[12:11]));
        if (got[13] != exp_rsp[13])
          report($sformatf("all_done %0d, want %0d", got[13], exp_rsp[13]));
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [2:0]  s_tuser = '0;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sched_scoreboard sb = new();
  bit quiet = 0;    // no idling on either side while set
  int stalled = 0;  // cycles since the last transfer of any kind

  always #5 clk = ~clk;

  round_robin_thread_scheduler u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Response side: check each transfer, then pick the ready level for the next cycle.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
    m_tready <= quiet || ($urandom_range(0, 99) >= 20);
  end

  // Watchdog on the time since any transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      stalled <= 0;
    else
      stalled <= stalled + 1;
    if (stalled >= WATCHDOG_LIMIT) begin
      $display("tb_round_robin_thread_scheduler failed");
      $finish;
    end
  end

  function automatic logic [39:0] pack_cmd(action_t act, logic [4:0] rid, bit root, bit fin,
                                           logic signed [24:0] lim);
    return {5'b0, lim, fin, root, rid, act};
  endfunction

  // One command transfer. Valid stays high into the next command unless a gap is drawn.
  task send_cmd(logic [39:0] cmd);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tuser <= cmd[2:0];
    s_tdata <= cmd[34:3];
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note(cmd);
  endtask

  // Register write, only with the block idle.
  task write_slice(logic [15:0] value);
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 3'(REG_SLICE_LEN * 4);
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.slice = value;
  endtask

  function automatic logic [39:0] random_cmd();
    int p;
    action_t act;
    logic signed [24:0] lim;
    p = $urandom_range(0, 99);
    if (p < 10) act = ACT_SPAWN;
    else if (p < 35) act = ACT_DISPATCH;
    else if (p < 60) act = ACT_SLICE;
    else if (p < 68) act = ACT_STOP;
    else if (p < 78) act = ACT_RESTART;
    else if (p < 88) act = ACT_QUERY;
    else if (p < 98) act = ACT_LIMIT;
    else act = ACT_NONE;
    p = $urandom_range(0, 99);
    if (p < 15) lim = -25'sd1;
    else if (p < 25) lim = 25'd16777215;
    else if (p < 75) lim = 25'($urandom_range(0, 3000));
    else lim = 25'($urandom_range(0, 16777215));
    return pack_cmd(act, 5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 3) == 0, lim);
  endfunction

  initial begin
    logic [15:0] slices[6];
    slices = '{16'd500, 16'd1, 16'd65535, 16'd0, 16'd2000, 16'd0};
    slices[3] = 16'($urandom_range(2, 1500));
    slices[5] = 16'($urandom_range(1, 65535));
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: empty table cases, then a small family of threads
    send_cmd(pack_cmd(ACT_NONE, 0, 0, 0, 0));
    send_cmd(pack_cmd(ACT_DISPATCH, 0, 0, 0, 0));
    send_cmd(pack_cmd(ACT_SLICE, 0, 0, 1, 0));
    send_cmd(pack_cmd(ACT_STOP, 5'd16, 0, 0, 0));
    send_cmd(pack_cmd(ACT_SPAWN, 0, 0, 0, 0));     // empty table: forced root
    send_cmd(pack_cmd(ACT_SPAWN, 0, 0, 0, 0));     // child of slot 0
    send_cmd(pack_cmd(ACT_SPAWN, 0, 1, 0, 0));     // root
    send_cmd(pack_cmd(ACT_DISPATCH, 0, 0, 0, 0));
    send_cmd(pack_cmd(ACT_SPAWN, 0, 0, 0, 0));     // child of slot 1
    send_cmd(pack_cmd(ACT_LIMIT, 5'd2, 0, 0, 25'd16777215));
    send_cmd(pack_cmd(ACT_LIMIT, 5'd3, 0, 0, 0));
    send_cmd(pack_cmd(ACT_LIMIT, 5'd1, 0, 0, -1));
    send_cmd(pack_cmd(ACT_SLICE, 0, 0, 0, 0));
    send_cmd(pack_cmd(ACT_QUERY, 5'd2, 0, 0, 0));
    send_cmd(pack_cmd(ACT_DISPATCH, 0, 0, 0, 0));
    send_cmd(pack_cmd(ACT_SLICE, 0, 0, 1, 0));     // finished but out of budget
    send_cmd(pack_cmd(ACT_QUERY, 5'd3, 0, 0, 0));
    send_cmd(pack_cmd(ACT_STOP, 5'd1, 0, 0, 0));   // descendants follow at next slice end
    send_cmd(pack_cmd(ACT_DISPATCH, 0, 0, 0, 0));
    send_cmd(pack_cmd(ACT_SLICE, 0, 0, 0, 0));
    send_cmd(pack_cmd(ACT_QUERY, 5'd4, 0, 0, 0));
    send_cmd(pack_cmd(ACT_RESTART, 5'd1, 0, 0, 0));
    send_cmd(pack_cmd(ACT_RESTART, 5'd20, 0, 0, 0));
    send_cmd(pack_cmd(ACT_SLICE, 0, 0, 1, 0));

    // random phases, one slice setting each; phase 2 runs with no idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_slice(slices[ph]);
      quiet = (ph == 2);
      for (int n = 0; n < 205; n++) send_cmd(random_cmd());
    end
    s_tvalid <= 0;
    quiet = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_round_robin_thread_scheduler passed");
    else
      $display("tb_round_robin_thread_scheduler failed");
    $finish;
  end

endmodule
